FILE: hdl/wam_pkg.sv
`default_nettype none

package wam_pkg;

    localparam int ENTRIES = 16;

    localparam int IDX_W  = 4;
    localparam int ADDR_W = 32;
    localparam int TYPE_W = 3;
    localparam int ID_W   = 16;
    localparam int WC_W   = 2;
    localparam int KIND_W = 2;
    localparam int VAL_W  = 32;

    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 120;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic [WC_W-1:0] WC_BYTE = 2'd0;
    localparam logic [WC_W-1:0] WC_HALF = 2'd1;
    localparam logic [WC_W-1:0] WC_WORD = 2'd2;

    localparam int TYPE_CHANGE_BIT = 2;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [WC_W-1:0]   width_code;
        logic [KIND_W-1:0] access_kind;
        logic [VAL_W-1:0]  new_value;
        logic [VAL_W-1:0]  old_value;
    } access_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  index;
        logic              valid;
        logic [ADDR_W-1:0] address;
        logic [TYPE_W-1:0] wtype;
        logic [ID_W-1:0]   id;
    } entry_wr_t;

    typedef struct packed {
        logic [TYPE_W-1:0] wtype;
        logic [ID_W-1:0]   id;
    } tag_t;

endpackage

`default_nettype wire

FILE: hdl/watchpoint_access_matcher.sv
// Watchpoint access matcher.
// Input stream s_*: one word per operation. s_tuser is the opcode: write a
// table entry, or check one memory access against the table. Output stream
// m_*: exactly one word per input word, in order. m_tuser is the hit flag;
// for table writes and misses all result fields are zero.
// Pipeline: input register, per-entry compare, then lowest-hit select into the
// output register. Throughput: one word per cycle while the output is not
// stalled, set by the three-stage pipeline with all table entries compared
// in parallel.
// A table write takes effect at the edge it is accepted; every later check
// sees it, every earlier one does not.
// Reset: all table entries invalid, pipeline empty, m_tvalid low.
// Stall: when m_tready is low with a word on the output, the whole pipeline
// holds and s_tready drops; nothing is lost or repeated.
`default_nettype none

module watchpoint_access_matcher (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // entry_index, entry_valid, entry_address, entry_type, entry_id, address,
    // width_code, access_kind, new_value, old_value, zero pad
    input  wire logic [wam_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // hit_point_id, hit_watch_type, hit_access_kind, hit_address,
    // hit_old_value, hit_new_value, zero pad
    output logic [wam_pkg::M_TDATA_W-1:0]        m_tdata,
    // hit
    output logic                                 m_tuser
);

    localparam int N = wam_pkg::ENTRIES;

    logic               adv;
    logic               s_fire;
    wam_pkg::entry_wr_t wr;
    wam_pkg::access_t   s_acc;

    logic               a_valid_reg;
    logic               a_check_reg;
    wam_pkg::access_t   a_acc_reg;

    logic               b_valid_reg;
    wam_pkg::access_t   b_acc_reg;
    logic [N-1:0]       b_match;
    wam_pkg::tag_t      b_tag [N];

    logic [N-1:0]       first_hit;
    wam_pkg::tag_t      sel_tag;
    logic               any_hit;

    logic                         m_valid_reg;
    logic                         m_hit_reg;
    logic [wam_pkg::ID_W-1:0]     m_id_reg;
    logic [wam_pkg::TYPE_W-1:0]   m_type_reg;
    logic [wam_pkg::KIND_W-1:0]   m_kind_reg;
    logic [wam_pkg::ADDR_W-1:0]   m_addr_reg;
    logic [wam_pkg::VAL_W-1:0]    m_old_reg;
    logic [wam_pkg::VAL_W-1:0]    m_new_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign s_fire   = s_tvalid && adv;

    assign wr.en      = s_fire && (s_tuser == wam_pkg::OP_WRITE);
    assign wr.index   = s_tdata[3:0];
    assign wr.valid   = s_tdata[4];
    assign wr.address = s_tdata[36:5];
    assign wr.wtype   = s_tdata[39:37];
    assign wr.id      = s_tdata[55:40];

    assign s_acc.address     = s_tdata[87:56];
    assign s_acc.width_code  = s_tdata[89:88];
    assign s_acc.access_kind = s_tdata[91:90];
    assign s_acc.new_value   = s_tdata[123:92];
    assign s_acc.old_value   = s_tdata[155:124];

    // stage A: input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            a_check_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_tvalid;
            a_check_reg <= s_tvalid && (s_tuser == wam_pkg::OP_CHECK);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_acc_reg <= s_acc;
        end
    end

    // stage B: per-entry compare
    wam_table u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .wr        (wr),
        .chk_valid (a_check_reg),
        .chk       (a_acc_reg),
        .match_reg (b_match),
        .tag_reg   (b_tag)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_acc_reg <= a_acc_reg;
        end
    end

    // stage C: lowest hit wins
    assign first_hit = b_match & (~b_match + N'(1));
    assign any_hit   = |b_match;

    always_comb begin
        sel_tag = '0;
        for (int i = 0; i < N; i++) begin
            if (first_hit[i]) begin
                sel_tag = sel_tag | b_tag[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            m_hit_reg   <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= b_valid_reg;
            m_hit_reg   <= any_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_id_reg   <= any_hit ? sel_tag.id : '0;
            m_type_reg <= any_hit ? sel_tag.wtype : '0;
            m_kind_reg <= any_hit ? b_acc_reg.access_kind : '0;
            m_addr_reg <= any_hit ? b_acc_reg.address : '0;
            m_old_reg  <= any_hit ? b_acc_reg.old_value : '0;
            m_new_reg  <= any_hit ? b_acc_reg.new_value : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = {3'b000, m_new_reg, m_old_reg, m_addr_reg,
                       m_kind_reg, m_type_reg, m_id_reg};

endmodule

`default_nettype wire

FILE: hdl/wam_table.sv
`default_nettype none

module wam_table (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               adv,
    input  wire wam_pkg::entry_wr_t wr,
    input  wire logic               chk_valid,
    input  wire wam_pkg::access_t   chk,
    output logic [wam_pkg::ENTRIES-1:0] match_reg,
    output wam_pkg::tag_t           tag_reg [wam_pkg::ENTRIES]
);

    localparam int N = wam_pkg::ENTRIES;

    logic                       valid_reg [N];
    logic [wam_pkg::ADDR_W-1:0] addr_reg  [N];
    logic [wam_pkg::TYPE_W-1:0] type_reg  [N];
    logic [wam_pkg::ID_W-1:0]   id_reg    [N];

    logic [wam_pkg::ADDR_W-1:0] low_mask;
    logic [wam_pkg::VAL_W-1:0]  value_mask;
    logic                       wc_ok;
    logic                       same_value;
    logic [N-1:0]               match_next;

    always_comb begin
        low_mask   = '0;
        value_mask = '0;
        wc_ok      = 1'b1;
        unique case (chk.width_code)
            wam_pkg::WC_BYTE: begin
                low_mask   = 32'h0000_0000;
                value_mask = 32'h0000_00FF;
            end
            wam_pkg::WC_HALF: begin
                low_mask   = 32'h0000_0001;
                value_mask = 32'h0000_FFFF;
            end
            wam_pkg::WC_WORD: begin
                low_mask   = 32'h0000_0003;
                value_mask = 32'hFFFF_FFFF;
            end
            default: begin
                wc_ok = 1'b0;
            end
        endcase
    end

    assign same_value = ((chk.new_value ^ chk.old_value) & value_mask) == '0;

    for (genvar i = 0; i < N; i++) begin : g_entry
        logic sel;

        assign sel = wr.en && (32'(wr.index) == 32'(i));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (sel) begin
                valid_reg[i] <= wr.valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (sel) begin
                addr_reg[i] <= wr.address;
                type_reg[i] <= wr.wtype;
                id_reg[i]   <= wr.id;
            end
        end

        assign match_next[i] = chk_valid && wc_ok && valid_reg[i]
            && (((addr_reg[i] ^ chk.address) & ~low_mask) == '0)
            && ((type_reg[i][wam_pkg::KIND_W-1:0] & chk.access_kind) != '0)
            && !(type_reg[i][wam_pkg::TYPE_CHANGE_BIT] && same_value);

        always_ff @(posedge aclk) begin
            if (adv) begin
                tag_reg[i].wtype <= type_reg[i];
                tag_reg[i].id    <= id_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= '0;
        end else if (adv) begin
            match_reg <= match_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wam_checker.sv
`default_nettype none

module wam_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [wam_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    a_miss_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss word carries nonzero fields");

    a_hit_overlaps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[17:16] & m_tdata[20:19]) != 2'b00)
        else $error("hit without type and kind overlap");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind watchpoint_access_matcher wam_checker u_wam_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam logic [wam_pkg::WC_W-1:0]   WC_NONE    = 2'd3;
    localparam logic [wam_pkg::KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [wam_pkg::KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [wam_pkg::KIND_W-1:0] KIND_WRITE = 2'd2;
    localparam logic [wam_pkg::KIND_W-1:0] KIND_BOTH  = 2'd3;
    localparam logic [wam_pkg::TYPE_W-1:0] TYPE_READ   = 3'b001;
    localparam logic [wam_pkg::TYPE_W-1:0] TYPE_WRITE  = 3'b010;
    localparam logic [wam_pkg::TYPE_W-1:0] TYPE_CHANGE = 3'b100;
    localparam int PHASE_ITEMS = 280;

    typedef struct packed {
        logic [3:0]                 pad;
        logic [wam_pkg::VAL_W-1:0]  old_value;
        logic [wam_pkg::VAL_W-1:0]  new_value;
        logic [wam_pkg::KIND_W-1:0] access_kind;
        logic [wam_pkg::WC_W-1:0]   width_code;
        logic [wam_pkg::ADDR_W-1:0] address;
        logic [wam_pkg::ID_W-1:0]   entry_id;
        logic [wam_pkg::TYPE_W-1:0] entry_type;
        logic [wam_pkg::ADDR_W-1:0] entry_address;
        logic                       entry_valid;
        logic [wam_pkg::IDX_W-1:0]  entry_index;
    } access_word_t;

    typedef struct packed {
        logic [2:0]                 pad;
        logic [wam_pkg::VAL_W-1:0]  new_value;
        logic [wam_pkg::VAL_W-1:0]  old_value;
        logic [wam_pkg::ADDR_W-1:0] address;
        logic [wam_pkg::KIND_W-1:0] access_kind;
        logic [wam_pkg::TYPE_W-1:0] watch_type;
        logic [wam_pkg::ID_W-1:0]   point_id;
    } hit_word_t;

    typedef struct {
        logic      hit;
        hit_word_t word;
    } hit_report_t;

    typedef struct {
        logic                       valid;
        logic [wam_pkg::ADDR_W-1:0] address;
        logic [wam_pkg::TYPE_W-1:0] wtype;
        logic [wam_pkg::ID_W-1:0]   id;
    } watch_slot_t;

    class watch_hit_predictor;
        watch_slot_t slots[wam_pkg::ENTRIES];
        hit_report_t expected_hits[$];
        int fail_count;

        function new();
            foreach (slots[i]) begin
                slots[i].valid = 1'b0;
                slots[i].address = '0;
                slots[i].wtype = '0;
                slots[i].id = '0;
            end
            fail_count = 0;
        endfunction

        function void note_word(logic op, access_word_t w);
            hit_report_t r;
            logic [wam_pkg::ADDR_W-1:0] low_mask;
            logic [wam_pkg::VAL_W-1:0] value_mask;
            logic found;
            r.hit = 1'b0;
            r.word = '0;
            found = 1'b0;
            low_mask = '0;
            value_mask = '1;
            if (op == wam_pkg::OP_WRITE) begin
                if (int'(w.entry_index) < wam_pkg::ENTRIES) begin
                    slots[w.entry_index].valid = w.entry_valid;
                    slots[w.entry_index].address = w.entry_address;
                    slots[w.entry_index].wtype = w.entry_type;
                    slots[w.entry_index].id = w.entry_id;
                end
            end else if (w.width_code != WC_NONE) begin
                case (w.width_code)
                    wam_pkg::WC_BYTE: begin
                        low_mask = 32'h0;
                        value_mask = 32'h0000_00FF;
                    end
                    wam_pkg::WC_HALF: begin
                        low_mask = 32'h1;
                        value_mask = 32'h0000_FFFF;
                    end
                    default: begin
                        low_mask = 32'h3;
                        value_mask = 32'hFFFF_FFFF;
                    end
                endcase
                for (int i = 0; i < wam_pkg::ENTRIES; i++) begin
                    if (!found && slots[i].valid
                        && ((slots[i].address ^ w.address) & ~low_mask) == '0
                        && (slots[i].wtype & {1'b0, w.access_kind}) != '0
                        && !(slots[i].wtype[wam_pkg::TYPE_CHANGE_BIT]
                             && (w.new_value & value_mask) == (w.old_value & value_mask)))
                    begin
                        found = 1'b1;
                        r.hit = 1'b1;
                        r.word.point_id = slots[i].id;
                        r.word.watch_type = slots[i].wtype;
                        r.word.access_kind = w.access_kind;
                        r.word.address = w.address;
                        r.word.old_value = w.old_value;
                        r.word.new_value = w.new_value;
                    end
                end
            end
            expected_hits.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s expected %0h actual %0h", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_hit(logic hit, hit_word_t got);
            hit_report_t want;
            if (expected_hits.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
                return;
            end
            want = expected_hits.pop_front();
            compare_field("hit", 32'(want.hit), 32'(hit));
            compare_field("hit_point_id", 32'(want.word.point_id), 32'(got.point_id));
            compare_field("hit_watch_type", 32'(want.word.watch_type), 32'(got.watch_type));
            compare_field("hit_access_kind", 32'(want.word.access_kind),
                          32'(got.access_kind));
            compare_field("hit_address", want.word.address, got.address);
            compare_field("hit_old_value", want.word.old_value, got.old_value);
            compare_field("hit_new_value", want.word.new_value, got.new_value);
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [wam_pkg::S_TDATA_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [wam_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tuser;

    watch_hit_predictor pred;
    logic [wam_pkg::ADDR_W-1:0] addr_pool[8];
    int tx_gap_odds = 0;
    int rx_stall_odds = 0;
    int rx_hold = 0;

    watchpoint_access_matcher i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            pred.check_hit(m_tuser, m_tdata);
        end
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
        end else if (rx_stall_odds != 0 && $urandom_range(1, 100) <= rx_stall_odds) begin
            rx_hold = $urandom_range(1, 10);
        end
        m_tready <= (rx_hold == 0);
    end

    function automatic void refresh_pool();
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++) begin
            addr_pool[i] = $urandom;
        end
    endfunction

    function automatic logic [wam_pkg::ADDR_W-1:0] near_address();
        if ($urandom_range(0, 9) < 7) begin
            return addr_pool[3'($urandom_range(0, 7))]
                ^ wam_pkg::ADDR_W'($urandom_range(0, 3));
        end
        return $urandom;
    endfunction

    function automatic access_word_t random_word();
        access_word_t w;
        int pick;
        w = '0;
        w.entry_index = wam_pkg::IDX_W'($urandom_range(0, 15));
        w.entry_valid = ($urandom_range(0, 99) < 85);
        w.entry_address = near_address();
        w.entry_type = wam_pkg::TYPE_W'($urandom_range(0, 7));
        w.entry_id = wam_pkg::ID_W'($urandom_range(0, 65535));
        w.address = near_address();
        w.width_code = ($urandom_range(0, 19) == 0) ? WC_NONE
                                                      : wam_pkg::WC_W'($urandom_range(0, 2));
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            w.access_kind = KIND_NONE;
        end else if (pick == 1) begin
            w.access_kind = KIND_BOTH;
        end else begin
            w.access_kind = ($urandom_range(0, 1) == 0) ? KIND_READ : KIND_WRITE;
        end
        w.new_value = $urandom;
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            w.old_value = w.new_value;
        end else if (pick < 5) begin
            w.old_value = {wam_pkg::VAL_W'($urandom)} & 32'hFFFF_FF00
                          | w.new_value & 32'h0000_00FF;
        end else if (pick < 6) begin
            w.old_value = {wam_pkg::VAL_W'($urandom)} & 32'hFFFF_0000
                          | w.new_value & 32'h0000_FFFF;
        end else begin
            w.old_value = $urandom;
        end
        return w;
    endfunction

    task automatic send_word(input logic op, input access_word_t w);
        if (tx_gap_odds != 0 && $urandom_range(1, 100) <= tx_gap_odds) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred.note_word(op, w);
    endtask

    task automatic write_entry(input logic [wam_pkg::IDX_W-1:0] idx, input logic enable,
                               input logic [wam_pkg::ADDR_W-1:0] addr,
                               input logic [wam_pkg::TYPE_W-1:0] wt,
                               input logic [wam_pkg::ID_W-1:0] id);
        access_word_t w;
        w = random_word();
        w.entry_index = idx;
        w.entry_valid = enable;
        w.entry_address = addr;
        w.entry_type = wt;
        w.entry_id = id;
        send_word(wam_pkg::OP_WRITE, w);
    endtask

    task automatic check_access(input logic [wam_pkg::ADDR_W-1:0] addr,
                                input logic [wam_pkg::WC_W-1:0] wc,
                                input logic [wam_pkg::KIND_W-1:0] kind,
                                input logic [wam_pkg::VAL_W-1:0] newv,
                                input logic [wam_pkg::VAL_W-1:0] oldv);
        access_word_t w;
        w = random_word();
        w.address = addr;
        w.width_code = wc;
        w.access_kind = kind;
        w.new_value = newv;
        w.old_value = oldv;
        send_word(wam_pkg::OP_CHECK, w);
    endtask

    task automatic drain_hits();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pred.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        s_tvalid = 1'b0;
        s_tuser = wam_pkg::OP_WRITE;
        s_tdata = '0;
        aresetn = 1'b0;
        pred = new();
        refresh_pool();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        check_access(32'h0000_0000, wam_pkg::WC_WORD, KIND_READ, 32'h0, 32'h0);
        write_entry(4'd0, 1'b1, 32'hFFFF_FFFF, TYPE_READ, 16'hFFFF);
        write_entry(4'd15, 1'b1, 32'h0000_0000, TYPE_WRITE, 16'h0000);
        write_entry(4'd3, 1'b1, 32'h0000_1000, TYPE_READ | TYPE_WRITE | TYPE_CHANGE, 16'h1234);
        write_entry(4'd5, 1'b1, 32'h0000_2000, TYPE_CHANGE, 16'h0055);
        check_access(32'hFFFF_FFFF, wam_pkg::WC_BYTE, KIND_READ, 32'h0, 32'h12);
        check_access(32'hFFFF_FFFC, wam_pkg::WC_WORD, KIND_READ, 32'h0, 32'hFFFF_FFFF);
        check_access(32'hFFFF_FFFE, wam_pkg::WC_BYTE, KIND_READ, 32'h0, 32'h1);
        check_access(32'hFFFF_FFFF, wam_pkg::WC_BYTE, KIND_WRITE, 32'h5, 32'h6);
        check_access(32'h0000_0000, wam_pkg::WC_BYTE, KIND_WRITE, 32'hAAAA_5555, 32'h0);
        check_access(32'h0000_0000, WC_NONE, KIND_WRITE, 32'h1, 32'h2);
        check_access(32'hFFFF_FFFF, wam_pkg::WC_BYTE, KIND_NONE, 32'h1, 32'h2);
        check_access(32'hFFFF_FFFF, wam_pkg::WC_BYTE, KIND_BOTH, 32'h1, 32'h2);
        check_access(32'h0000_1000, wam_pkg::WC_WORD, KIND_WRITE, 32'h1234_5678,
                     32'h1234_5678);
        check_access(32'h0000_1000, wam_pkg::WC_BYTE, KIND_WRITE, 32'h1234_5678,
                     32'hAB34_5678);
        check_access(32'h0000_1000, wam_pkg::WC_WORD, KIND_WRITE, 32'h1234_5678,
                     32'hAB34_5678);
        check_access(32'h0000_1001, wam_pkg::WC_HALF, KIND_READ, 32'h0000_BEEF,
                     32'h0001_BEEF);
        check_access(32'h0000_1001, wam_pkg::WC_HALF, KIND_READ, 32'h0000_0001,
                     32'h0000_0002);
        check_access(32'h0000_2000, wam_pkg::WC_BYTE, KIND_READ, 32'h1, 32'h2);
        check_access(32'h0000_2000, wam_pkg::WC_BYTE, KIND_WRITE, 32'h1, 32'h2);
        write_entry(4'd1, 1'b1, 32'h0000_1000, TYPE_WRITE, 16'h0101);
        check_access(32'h0000_1000, wam_pkg::WC_WORD, KIND_WRITE, 32'h1, 32'h2);
        write_entry(4'd1, 1'b0, 32'h0000_1000, TYPE_WRITE, 16'h0101);
        check_access(32'h0000_1000, wam_pkg::WC_WORD, KIND_WRITE, 32'h1, 32'h2);
        drain_hits();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    tx_gap_odds = 20;
                    rx_stall_odds <= 20;
                end
                1: begin
                    tx_gap_odds = 50;
                    rx_stall_odds <= 0;
                end
                2: begin
                    tx_gap_odds = 0;
                    rx_stall_odds <= 50;
                end
                3: begin
                    tx_gap_odds = 10;
                    rx_stall_odds <= 10;
                end
                default: begin
                    tx_gap_odds = 0;
                    rx_stall_odds <= 0;
                end
            endcase
            refresh_pool();
            repeat (PHASE_ITEMS) begin
                send_word(($urandom_range(0, 99) < 25) ? wam_pkg::OP_WRITE : wam_pkg::OP_CHECK,
                          random_word());
            end
            drain_hits();
        end

        repeat (8) @(posedge aclk);
        if (pred.fail_count == 0 && pred.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
